// ===== rtl/core/dcdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dcdf_pkg;

  localparam int unsigned COLS_DEFAULT = 80;
  localparam int unsigned ROWS_DEFAULT = 25;

  // memory word: {dirty, bank select, bank_b, bank_a}
  localparam int unsigned CELL_W = 32;
  localparam int unsigned MEM_W = 2 * CELL_W + 2;
  localparam int unsigned BANK_POS = 2 * CELL_W;
  localparam int unsigned DIRTY_POS = 2 * CELL_W + 1;

  localparam logic [11:0] RUNS_MAX = 12'd4095;

  typedef enum logic [2:0] {
    F_PUT = 3'd0,
    F_PICK = 3'd1,
    F_RSTART = 3'd2,
    F_RNEXT = 3'd3,
    F_REND = 3'd4,
    F_CLEAR = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    K_PUT = 3'd0,
    K_PICK = 3'd1,
    K_RUNCHAR = 3'd2,
    K_RUNEND = 3'd3,
    K_DONE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    kind_e kind;
    logic ok;
    logic [7:0] out_glyph;
    logic [7:0] out_fore;
    logic [7:0] out_back;
    logic [7:0] out_style;
    logic [7:0] run_col;
    logic [7:0] run_row;
    logic [7:0] run_len;
    logic [11:0] draw_count;
    logic last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/dcdf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dcdf_in_if;
  logic valid;
  logic ready;
  logic [2:0] func;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] glyph;
  logic [7:0] fore_color;
  logic [7:0] back_color;
  logic [7:0] style_bits;

  modport source (
    output valid, func, col, row, glyph, fore_color, back_color, style_bits,
    input ready
  );
  modport sink (
    input valid, func, col, row, glyph, fore_color, back_color, style_bits,
    output ready
  );
endinterface

interface dcdf_out_if;
  logic valid;
  logic ready;
  logic [2:0] kind;
  logic ok;
  logic [7:0] out_glyph;
  logic [7:0] out_fore;
  logic [7:0] out_back;
  logic [7:0] out_style;
  logic [7:0] run_col;
  logic [7:0] run_row;
  logic [7:0] run_len;
  logic [11:0] draw_count;
  logic last;

  modport source (
    output valid, kind, ok, out_glyph, out_fore, out_back, out_style,
    output run_col, run_row, run_len, draw_count, last,
    input ready
  );
  modport sink (
    input valid, kind, ok, out_glyph, out_fore, out_back, out_style,
    input run_col, run_row, run_len, draw_count, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/dcdf_cell_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcdf_cell_mem #(
  parameter int unsigned DEPTH = dcdf_pkg::COLS_DEFAULT * dcdf_pkg::ROWS_DEFAULT,
  parameter int unsigned AW = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [dcdf_pkg::MEM_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [dcdf_pkg::MEM_W-1:0] rdata_o
);
  import dcdf_pkg::*;

  logic [MEM_W-1:0] mem_q [DEPTH];
  logic [MEM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/dirty_cell_double_framebuffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Double-banked character-cell screen store. Every cell sits in one
// synchronous memory word together with its bank-select and dirty bits, so
// each transaction is a read at accept followed by a modify-and-write in the
// execute state; the next item is accepted while up to two results
// wait in the output queue; it then holds in the execute state until that
// queue has drained. After reset and after a clear-all the block sweeps
// the memory to empty cells, one cell per cycle (COLUMNS*ROWS cells), and
// takes no item meanwhile. A render next-cell item can give a run end and a
// run character; a render end can give a run end and the done report.
module dirty_cell_double_framebuffer #(
  parameter int unsigned COLUMNS = dcdf_pkg::COLS_DEFAULT,
  parameter int unsigned ROWS = dcdf_pkg::ROWS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcdf_in_if.sink    in_i,
  dcdf_out_if.source out_o
);
  import dcdf_pkg::*;

  localparam int unsigned AREA = COLUMNS * ROWS;
  localparam int unsigned AW = (AREA > 1) ? $clog2(AREA) : 1;
  localparam int unsigned IW = $clog2(AREA + 1);
  localparam logic [7:0] COLS8 = 8'(COLUMNS);
  localparam logic [7:0] ROWS8 = 8'(ROWS);
  localparam logic [IW-1:0] AREA_I = IW'(AREA);
  localparam logic [AW-1:0] LAST_A = AW'(AREA - 1);

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;

  // latched item
  func_e func_q;
  logic inside_q;
  logic [CELL_W-1:0] cell_q;

  // render state
  logic any_dirty_q, any_dirty_d;
  logic skip_q, skip_d;
  logic [IW-1:0] scan_q, scan_d;
  logic [7:0] scol_q, scol_d, srow_q, srow_d;
  logic prev_valid_q, prev_valid_d;
  logic [IW-1:0] prev_q, prev_d;
  logic [7:0] plen_q, plen_d, pcol_q, pcol_d, prow_q, prow_d;
  logic [CELL_W-1:0] lcell_q, lcell_d;
  logic [11:0] runs_q, runs_d;

  // result queue
  res_t res_q [2];
  res_t res_d [2];
  logic [1:0] cnt_q, cnt_d;

  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr, mem_raddr_q;
  logic [MEM_W-1:0] mem_wdata, rd;

  logic in_acc, out_acc, in_inside;
  logic [15:0] in_idx;

  dcdf_cell_mem #(
    .DEPTH(AREA),
    .AW(AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(rd)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign in_inside = (in_i.col < COLS8) && (in_i.row < ROWS8);
  assign in_idx = 16'(in_i.row) * 16'(COLS8) + 16'(in_i.col);

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.kind = res_q[0].kind;
  assign out_o.ok = res_q[0].ok;
  assign out_o.out_glyph = res_q[0].out_glyph;
  assign out_o.out_fore = res_q[0].out_fore;
  assign out_o.out_back = res_q[0].out_back;
  assign out_o.out_style = res_q[0].out_style;
  assign out_o.run_col = res_q[0].run_col;
  assign out_o.run_row = res_q[0].run_row;
  assign out_o.run_len = res_q[0].run_len;
  assign out_o.draw_count = res_q[0].draw_count;
  assign out_o.last = res_q[0].last;

  // read address at accept
  always_comb begin
    mem_re = in_acc;
    mem_raddr = '0;
    if (func_e'(in_i.func) == F_RNEXT) begin
      if (scan_q < AREA_I) begin
        mem_raddr = scan_q[AW-1:0];
      end
    end else if (in_inside) begin
      mem_raddr = in_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_e'(in_i.func);
      inside_q <= in_inside;
      cell_q <= {in_i.style_bits, in_i.back_color, in_i.fore_color, in_i.glyph};
    end
  end

  logic [CELL_W-1:0] ba, bb, nxt, cur;
  logic bsel, dirty, cont, flush, wrote;
  logic [7:0] plen1;
  logic [11:0] runs_inc;
  res_t rend, rone;

  always_comb begin
    ba = rd[CELL_W-1:0];
    bb = rd[2*CELL_W-1:CELL_W];
    bsel = rd[BANK_POS];
    dirty = rd[DIRTY_POS];
    nxt = bsel ? bb : ba;
    cur = bsel ? ba : bb;
    runs_inc = (runs_q < RUNS_MAX) ? runs_q + 12'd1 : runs_q;
    cont = prev_valid_q && ({1'b0, prev_q} + {{IW{1'b0}}, 1'b1} == {1'b0, scan_q});
    flush = 1'b0;
    wrote = 1'b0;
    plen1 = plen_q;

    rend = '0;
    rend.kind = K_RUNEND;
    rend.out_fore = lcell_q[15:8];
    rend.out_back = lcell_q[23:16];
    rend.out_style = lcell_q[31:24];
    rend.run_col = pcol_q;
    rend.run_row = prow_q;
    rend.run_len = plen_q;
    rone = '0;

    state_d = state_q;
    clr_d = clr_q;
    any_dirty_d = any_dirty_q;
    skip_d = skip_q;
    scan_d = scan_q;
    scol_d = scol_q;
    srow_d = srow_q;
    prev_valid_d = prev_valid_q;
    prev_d = prev_q;
    plen_d = plen_q;
    pcol_d = pcol_q;
    prow_d = prow_q;
    lcell_d = lcell_q;
    runs_d = runs_q;
    res_d = res_q;
    cnt_d = cnt_q;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd;

    if (out_acc) begin
      res_d[0] = res_q[1];
      cnt_d = cnt_q - 2'd1;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_A) begin
          clr_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cnt_q == 2'd0) begin
          state_d = ST_IDLE;
          case (func_q)
            F_PUT: begin
              // write back to the word that was read
              mem_waddr = mem_raddr_q;
              if (inside_q && (nxt != cell_q)) begin
                if (dirty || (cell_q != cur)) begin
                  wrote = 1'b1;
                  mem_we = 1'b1;
                  any_dirty_d = 1'b1;
                  if (bsel) begin
                    mem_wdata[2*CELL_W-1:CELL_W] = cell_q;
                  end else begin
                    mem_wdata[CELL_W-1:0] = cell_q;
                  end
                  mem_wdata[DIRTY_POS] = (cell_q != cur);
                end
              end
              rone.kind = K_PUT;
              rone.ok = wrote;
              rone.last = 1'b1;
              res_d[0] = rone;
              cnt_d = 2'd1;
            end
            F_PICK: begin
              rone.kind = K_PICK;
              if (inside_q) begin
                rone.ok = 1'b1;
                {rone.out_style, rone.out_back, rone.out_fore, rone.out_glyph} =
                  dirty ? nxt : cur;
              end
              rone.last = 1'b1;
              res_d[0] = rone;
              cnt_d = 2'd1;
            end
            F_RSTART: begin
              skip_d = !any_dirty_q;
              scan_d = '0;
              scol_d = '0;
              srow_d = '0;
              prev_valid_d = 1'b0;
              prev_d = '0;
              plen_d = '0;
              pcol_d = '0;
              prow_d = '0;
              lcell_d = '0;
              runs_d = '0;
            end
            F_RNEXT: begin
              if (!skip_q && (scan_q < AREA_I)) begin
                // a run breaks on a gap, a full row's worth, or a colour or style change
                flush = (plen_q != 8'd0) &&
                        ((!cont && (scan_q != '0)) || (plen_q == COLS8) ||
                         (dirty && cont && (nxt[31:8] != lcell_q[31:8])));
                if (flush) begin
                  plen1 = 8'd0;
                  runs_d = runs_inc;
                end
                plen_d = plen1;
                if (dirty) begin
                  if (plen1 == 8'd0) begin
                    pcol_d = scol_q;
                    prow_d = srow_q;
                  end
                  plen_d = plen1 + 8'd1;
                  lcell_d = nxt;
                  prev_valid_d = 1'b1;
                  prev_d = scan_q;
                  mem_we = 1'b1;
                  mem_waddr = scan_q[AW-1:0];
                  mem_wdata[BANK_POS] = !bsel;
                  mem_wdata[DIRTY_POS] = 1'b0;
                  rone.kind = K_RUNCHAR;
                  rone.out_glyph = nxt[7:0];
                  rone.last = 1'b1;
                end
                if (flush && dirty) begin
                  res_d[0] = rend;
                  res_d[1] = rone;
                  cnt_d = 2'd2;
                end else if (flush) begin
                  rend.last = 1'b1;
                  res_d[0] = rend;
                  cnt_d = 2'd1;
                end else if (dirty) begin
                  res_d[0] = rone;
                  cnt_d = 2'd1;
                end
                scan_d = scan_q + IW'(1);
                if (scol_q == COLS8 - 8'd1) begin
                  scol_d = '0;
                  srow_d = srow_q + 8'd1;
                end else begin
                  scol_d = scol_q + 8'd1;
                end
              end
            end
            F_REND: begin
              rone.kind = K_DONE;
              rone.last = 1'b1;
              if (!skip_q) begin
                any_dirty_d = 1'b0;
                if (plen_q != 8'd0) begin
                  rone.draw_count = runs_inc;
                  res_d[0] = rend;
                  res_d[1] = rone;
                  cnt_d = 2'd2;
                end else begin
                  rone.draw_count = runs_q;
                  res_d[0] = rone;
                  cnt_d = 2'd1;
                end
              end else begin
                res_d[0] = rone;
                cnt_d = 2'd1;
              end
              skip_d = 1'b1;
              runs_d = '0;
              plen_d = '0;
            end
            F_CLEAR: begin
              state_d = ST_CLEAR;
              clr_d = '0;
              any_dirty_d = 1'b0;
              skip_d = 1'b0;
              scan_d = '0;
              scol_d = '0;
              srow_d = '0;
              prev_valid_d = 1'b0;
              prev_d = '0;
              plen_d = '0;
              pcol_d = '0;
              prow_d = '0;
              lcell_d = '0;
              runs_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // write address of a put is the address it was read from
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_raddr_q <= mem_raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      any_dirty_q <= 1'b0;
      skip_q <= 1'b0;
      scan_q <= '0;
      scol_q <= '0;
      srow_q <= '0;
      prev_valid_q <= 1'b0;
      prev_q <= '0;
      plen_q <= '0;
      pcol_q <= '0;
      prow_q <= '0;
      lcell_q <= '0;
      runs_q <= '0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      any_dirty_q <= any_dirty_d;
      skip_q <= skip_d;
      scan_q <= scan_d;
      scol_q <= scol_d;
      srow_q <= srow_d;
      prev_valid_q <= prev_valid_d;
      prev_q <= prev_d;
      plen_q <= plen_d;
      pcol_q <= pcol_d;
      prow_q <= prow_d;
      lcell_q <= lcell_d;
      runs_q <= runs_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire
